// ===== hdl/dvc_pkg.sv =====
// Package for the distinct value counter: shared types and constants.
// No dependencies.
`default_nettype none

package dvc_pkg;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 16;
  localparam int SUM_W   = 38;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef struct packed {
    logic               valid;
    logic [VALUE_W-1:0] value;
  } token_t;

  typedef struct packed {
    logic               valid;
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] count;
  } entry_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_DRAIN,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

// ===== hdl/dvc_if.sv =====
// Valid/ready channel interfaces for sample words and result words.
// Depends on nothing but the port widths of the block.
`default_nettype none

interface dvc_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample_value;
  logic               last_item;

  modport source (output valid, output sample_value, output last_item, input ready);
  modport sink (input valid, input sample_value, input last_item, output ready);
endinterface

interface dvc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] distinct_value;
  logic        [15:0] occurrences;
  logic signed [37:0] distinct_sum;
  logic               overflow;
  logic               last_result;

  modport source (output valid, output distinct_value, output occurrences,
                  output distinct_sum, output overflow, output last_result, input ready);
  modport sink (input valid, input distinct_value, input occurrences,
                input distinct_sum, input overflow, input last_result, output ready);
endinterface

`default_nettype wire

// ===== hdl/dvc_cell.sv =====
// One table cell: holds one entry and passes unmatched sample tokens on.
// Depends on dvc_pkg.
`default_nettype none

module dvc_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            shift,
  input  wire dvc_pkg::token_t tok_in,
  output dvc_pkg::token_t      tok_out,
  input  wire dvc_pkg::entry_t ent_in,
  output dvc_pkg::entry_t      ent
);
  import dvc_pkg::*;

  logic hit;
  logic claim;

  assign hit   = tok_in.valid && ent.valid && (ent.value == tok_in.value);
  assign claim = tok_in.valid && !ent.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else if (shift) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid && !hit && !claim;
    end
    tok_out.value <= tok_in.value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
    end else if (shift) begin
      ent.valid <= ent_in.valid;
    end else if (claim) begin
      ent.valid <= 1'b1;
    end
    if (shift) begin
      ent.value <= ent_in.value;
      ent.count <= ent_in.count;
    end else if (claim) begin
      ent.value <= tok_in.value;
      ent.count <= COUNT_W'(1);
    end else if (hit && ent.count != COUNT_MAX) begin
      ent.count <= ent.count + COUNT_W'(1);
    end
  end

endmodule

`default_nettype wire

// ===== hdl/distinct_value_counter_unit.sv =====
// Distinct value counter: histogram of signed 32-bit samples in order of
// first appearance, built as a row of compare-and-pass cells.
// Depends on dvc_pkg, dvc_in_if, dvc_out_if and dvc_cell.
//
// samples: one signed word per accepted sample; last_item closes a set.
// While a set loads, one sample is taken every cycle. Each sample travels
// the cell row one cell per cycle; a matching cell bumps its count
// (saturating at 65535), the first empty cell claims a new value, and a
// sample that leaves the end of the row unclaimed sets the overflow flag.
// After the last sample the row drains, then entries shift out of cell 0
// one per cycle into the output register while it is free or being read,
// in order of first appearance. distinct_sum is carried on the final word
// only and is zero on the others; overflow is carried on every word.
// A stalled receiver holds the output register and the row stops shifting;
// the next set is accepted once the final word sits in the output register.
// Reset empties the table and the channels.
`default_nettype none

module distinct_value_counter_unit #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  dvc_in_if.sink    samples,
  dvc_out_if.source entries
);
  import dvc_pkg::*;

  localparam int DRAIN_W = $clog2(TABLE_DEPTH + 2);

  state_t state;
  state_t state_next;

  token_t tok [0:TABLE_DEPTH];
  entry_t ent [0:TABLE_DEPTH];

  logic               accept;
  logic               step;
  logic               final_word;
  logic               drain_done;
  logic [DRAIN_W-1:0] drain_cnt;
  logic               ovf;
  logic [SUM_W-1:0]   sum_acc;
  logic [SUM_W-1:0]   head_sum;

  assign samples.ready = (state == ST_LOAD);
  assign accept        = samples.valid && samples.ready;
  assign drain_done    = (drain_cnt == DRAIN_W'(TABLE_DEPTH));
  assign step          = (state == ST_EMIT) && (!entries.valid || entries.ready);
  assign final_word    = !ent[1].valid;
  assign head_sum      = sum_acc + {{(SUM_W-VALUE_W){ent[0].value[VALUE_W-1]}}, ent[0].value};

  assign tok[0].valid = accept;
  assign tok[0].value = samples.sample_value;
  assign ent[TABLE_DEPTH] = '0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    dvc_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .shift   (step),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1]),
      .ent_in  (ent[i+1]),
      .ent     (ent[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (accept && samples.last_item) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (drain_done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (step && final_word) state_next = ST_LOAD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drain_cnt <= '0;
    end else if (state == ST_DRAIN) begin
      drain_cnt <= drain_cnt + DRAIN_W'(1);
    end else begin
      drain_cnt <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovf     <= 1'b0;
      sum_acc <= '0;
    end else if (step) begin
      sum_acc <= final_word ? '0 : head_sum;
      if (final_word) ovf <= 1'b0;
    end else if (tok[TABLE_DEPTH].valid) begin
      ovf <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entries.valid <= 1'b0;
    end else if (step) begin
      entries.valid <= 1'b1;
    end else if (entries.ready) begin
      entries.valid <= 1'b0;
    end
    if (step) begin
      entries.distinct_value <= ent[0].value;
      entries.occurrences    <= ent[0].count;
      entries.distinct_sum   <= final_word ? head_sum : '0;
      entries.overflow       <= ovf;
      entries.last_result    <= final_word;
    end
  end

  a_row_packed: assert property (@(posedge clk) disable iff (rst)
    !ent[1].valid || ent[0].valid)
    else $error("table row has a gap at its head");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> ent[0].valid)
    else $error("emission with an empty table");

  a_sum_final_only: assert property (@(posedge clk) disable iff (rst)
    entries.valid && !entries.last_result |-> entries.distinct_sum == '0)
    else $error("sum on a word that is not final");

  a_ovf_not_in_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(ovf) |-> $past(state) != ST_EMIT)
    else $error("overflow raised during emission");

endmodule

`default_nettype wire

// ===== dv/distinct_value_counter_unit_tb.sv =====
// Testbench for distinct_value_counter_unit: a directed table, then random sample
// sets, with results checked word by word against an in-bench histogram predictor.
// Depends on dvc_pkg, dvc_in_if, dvc_out_if and the block itself.
`default_nettype none

module distinct_value_counter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dvc_pkg::*;

  localparam int TABLE_DEPTH  = 64;
  localparam int LONG_HOLD    = 400;
  localparam int RANDOM_ITEMS = 270;
  localparam int PLAN_ROWS    = 17;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic        [COUNT_W-1:0] count;
    logic signed [SUM_W-1:0]   sum;
    logic                      ovf;
    logic                      fin;
  } entry_word_t;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    int                        rep;
    int                        step;
    bit                        last;
    bit                        fixed;
    logic        [COUNT_W-1:0] exp_count;
    logic signed [SUM_W-1:0]   exp_sum;
  } plan_row_t;

  // value, repeats, step per repeat, last on final repeat, typed result, count, sum
  plan_row_t plan [PLAN_ROWS] = '{
    '{32'sh8000_0000, 1,     0,  1'b1, 1'b1, 16'd1, -38'sd2147483648},
    '{32'sh7FFF_FFFF, 1,     0,  1'b1, 1'b1, 16'd1, 38'sd2147483647},
    '{32'sd0,         1,     0,  1'b1, 1'b1, 16'd1, 38'sd0},
    '{-32'sd1,        1,     0,  1'b1, 1'b1, 16'd1, -38'sd1},
    '{32'sh5555_5555, 1,     0,  1'b1, 1'b1, 16'd1, 38'sd1431655765},
    '{32'shAAAA_AAAA, 1,     0,  1'b1, 1'b1, 16'd1, -38'sd1431655766},
    '{32'sd5,         3,     0,  1'b0, 1'b0, 16'd0, 38'sd0},
    '{-32'sd7,        2,     0,  1'b0, 1'b0, 16'd0, 38'sd0},
    '{32'sd5,         1,     0,  1'b0, 1'b0, 16'd0, 38'sd0},
    '{32'sh8000_0000, 1,     0,  1'b0, 1'b0, 16'd0, 38'sd0},
    '{32'sh7FFF_FFFF, 1,     0,  1'b0, 1'b0, 16'd0, 38'sd0},
    '{-32'sd7,        1,     0,  1'b1, 1'b0, 16'd0, 38'sd0},
    '{32'sh7FFF_FFFF, 64,    -1, 1'b1, 1'b0, 16'd0, 38'sd0},
    '{32'sh8000_0000, 64,    1,  1'b1, 1'b0, 16'd0, 38'sd0},
    '{32'sd1000,      66,    1,  1'b0, 1'b0, 16'd0, 38'sd0},
    '{32'sd1003,      1,     0,  1'b1, 1'b0, 16'd0, 38'sd0},
    '{32'sd7,         1,     0,  1'b1, 1'b1, 16'd1, 38'sd7}
  };

  logic clk;
  logic rst;

  dvc_in_if  samples ();
  dvc_out_if entries ();

  distinct_value_counter_unit #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .entries (entries)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // histogram predictor
  logic signed [VALUE_W-1:0] tab_value [TABLE_DEPTH];
  logic        [COUNT_W-1:0] tab_count [TABLE_DEPTH];
  int                        tab_used = 0;
  logic                      tab_ovf = 1'b0;
  entry_word_t               pending_entries [$];
  int                        fails = 0;

  logic        fixed_pending;
  entry_word_t fixed_word;

  function automatic void tally_sample(logic signed [VALUE_W-1:0] v, logic closes_set);
    int                      hit;
    int                      i;
    logic signed [SUM_W-1:0] total;
    entry_word_t             w;
    hit = -1;
    total = '0;
    for (i = 0; i < tab_used; i++)
      if (hit < 0 && tab_value[i] == v) hit = i;
    if (hit >= 0) begin
      if (tab_count[hit] != COUNT_MAX) tab_count[hit] = tab_count[hit] + 1'b1;
    end else if (tab_used < TABLE_DEPTH) begin
      tab_value[tab_used] = v;
      tab_count[tab_used] = 16'd1;
      tab_used++;
    end else begin
      tab_ovf = 1'b1;
    end
    if (closes_set) begin
      for (i = 0; i < tab_used; i++) total += tab_value[i];
      for (i = 0; i < tab_used; i++) begin
        w.value = tab_value[i];
        w.count = tab_count[i];
        w.fin   = (i == tab_used - 1);
        w.sum   = w.fin ? total : '0;
        w.ovf   = tab_ovf;
        pending_entries = {pending_entries, w};
      end
      tab_used = 0;
      tab_ovf = 1'b0;
    end
  endfunction

  function automatic void compare_field(string name, logic signed [63:0] want,
                                        logic signed [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  function automatic int pick_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm = $urandom_range(8, 40);
    return $urandom_range(0, 13);
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return 32'sd0;
      3: return -32'sd1;
      default: return $urandom();
    endcase
  endfunction

  always @(posedge clk) begin : watch
    entry_word_t want;
    if (!rst) begin
      if (samples.valid && samples.ready) begin
        tally_sample(samples.sample_value, samples.last_item);
        if (fixed_pending && samples.last_item) begin
          pending_entries[pending_entries.size() - 1] = fixed_word;
        end
      end
      if (entries.valid && entries.ready) begin
        if (pending_entries.size() == 0) begin
          $error("result word with none expected: distinct_value %0d",
                 entries.distinct_value);
          fails++;
        end else begin
          want = pending_entries.pop_front();
          compare_field("distinct_value", want.value, entries.distinct_value);
          compare_field("occurrences", want.count, entries.occurrences);
          compare_field("distinct_sum", want.sum, entries.distinct_sum);
          compare_field("overflow", want.ovf, entries.overflow);
          compare_field("last_result", want.fin, entries.last_result);
        end
      end
    end
  end

  task automatic send_word(input logic signed [VALUE_W-1:0] v, input logic closes_set,
                           input int gap, input logic fix, input entry_word_t fw);
    @(negedge clk);
    fixed_pending = fix;
    fixed_word = fw;
    if (gap > 0) begin
      samples.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    samples.valid        <= 1'b1;
    samples.sample_value <= v;
    samples.last_item    <= closes_set;
    do @(posedge clk); while (!samples.ready);
  endtask

  initial begin : sink_side
    int stall;
    int taken;
    int calm;
    entries.ready = 1'b0;
    taken = 0;
    calm = 0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      stall = pick_wait(calm);
      // long hold so that the row backs up and stalls the sample side
      if (taken == 40) stall = LONG_HOLD;
      if (stall > 0) begin
        entries.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      entries.ready <= 1'b1;
      do @(posedge clk); while (!entries.valid);
      taken++;
    end
  end

  initial begin : source_side
    int                        r;
    int                        i;
    int                        kind;
    int                        size;
    int                        npool;
    int                        random_sent;
    int                        send_calm;
    bit                        paused;
    logic signed [VALUE_W-1:0] v;
    logic signed [VALUE_W-1:0] base;
    logic signed [VALUE_W-1:0] pool [6];
    entry_word_t               fw;
    rst = 1'b1;
    samples.valid = 1'b0;
    samples.sample_value = '0;
    samples.last_item = 1'b0;
    fixed_pending = 1'b0;
    fixed_word = '0;
    send_calm = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (r = 0; r < PLAN_ROWS; r++) begin
      v = plan[r].value;
      fw = '{plan[r].value, plan[r].exp_count, plan[r].exp_sum, 1'b0, 1'b1};
      for (i = 0; i < plan[r].rep; i++) begin
        send_word(v, plan[r].last && i == plan[r].rep - 1,
                  (i < 16) ? pick_wait(send_calm) : 0, plan[r].fixed, fw);
        v = v + plan[r].step;
      end
    end

    random_sent = 0;
    paused = 1'b0;
    while (random_sent < RANDOM_ITEMS) begin
      if (!paused && random_sent >= RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        @(negedge clk);
        samples.valid <= 1'b0;
        while (pending_entries.size() != 0) @(posedge clk);
      end
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        size = $urandom_range(1, 10);
        npool = $urandom_range(1, 6);
        for (i = 0; i < npool; i++) pool[i] = pick_value();
      end else if (kind < 8) begin
        size = $urandom_range(10, 40);
      end else if (kind == 8) begin
        size = $urandom_range(70, 80);
        base = $urandom();
      end else begin
        size = 1;
      end
      for (i = 0; i < size; i++) begin
        if (kind < 6) v = pool[$urandom_range(0, npool - 1)];
        else if (kind == 8)
          v = ($urandom_range(0, 5) == 0) ? base + $urandom_range(0, i) : base + i;
        else v = $urandom();
        send_word(v, i == size - 1, pick_wait(send_calm), 1'b0, '0);
        random_sent++;
      end
    end

    @(negedge clk);
    samples.valid <= 1'b0;
    while (pending_entries.size() != 0) @(posedge clk);
    repeat (3 * TABLE_DEPTH) @(posedge clk);
    if (fails == 0) begin
      $display("PASS distinct_value_counter_unit");
    end else begin
      $display("FAIL distinct_value_counter_unit");
    end
    $finish;
  end

  initial begin : watchdog
    #10ms;
    $display("FAIL distinct_value_counter_unit");
    $finish;
  end

endmodule

`default_nettype wire

// ===== distinct_value_counter_unit.f =====
hdl/dvc_pkg.sv
hdl/dvc_if.sv
hdl/dvc_cell.sv
hdl/distinct_value_counter_unit.sv
dv/distinct_value_counter_unit_tb.sv
